>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/pva_pkg.sv
package pva_pkg;

   localparam int VOICES_DEF   = 16;
   localparam int AGE_BITS_DEF = 32;
   localparam int MAX_RESULTS  = 16;
   localparam int DONE_BITS    = 16;
   localparam int VOICE_BITS   = 4;

   localparam int REQ_W = 40;
   localparam int RSP_W = 24;

   localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;

   localparam logic [2:0] OP_NOTE_ON  = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF = 3'd1;
   localparam logic [2:0] OP_SUSTAIN  = 3'd2;
   localparam logic [2:0] OP_ALL_OFF  = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_KEYUP = 2'd2;

   // action in the lowest bits, as on the stream
   typedef struct packed {
      logic [6:0] velocity;
      logic [6:0] note;
      logic [3:0] voice;
      logic [1:0] action;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

   // fin marks the end of one input transaction's results
   typedef struct packed {
      logic    valid;
      logic    fin;
      rsp_type rsp;
   } push_type;

endpackage

>>> rtl/poly_voice_allocator.sv
// Voice allocator for a polyphonic synthesiser. Each request transaction
// (note on, note off, sustain pedal, all notes off, block tick) produces one
// or more response transactions, the final one flagged by rsp_tlast; a request
// that starts or keys up nothing yields a single response with action 0. The
// per-voice record (active, note, sustained, age) lives in a single-port-write
// RAM read one voice per cycle while the response side does not stall; valid
// flags cleared at reset make unwritten voices read as idle, so no clearing
// pass is needed. A request is accepted in the idle state, every voice is then
// scanned in turn, and a closing state sends the final response; a note on
// with nonzero velocity adds a state after the scan that writes the chosen
// voice. A pedal press or an unused op goes from acceptance straight to the
// closing state. Requests are taken one at a time.
`include "assert_macros.svh"

module poly_voice_allocator #(
   parameter int VOICES   = pva_pkg::VOICES_DEF,
   parameter int AGE_BITS = pva_pkg::AGE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // op[2:0], note[9:3], velocity[16:10], pedal_value[23:17], done_mask[39:24]
   input  logic [pva_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // action[1:0], voice[5:2], out_note[12:6], out_velocity[19:13], zero[23:20]
   output logic [pva_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   import pva_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int EW = AGE_BITS + 9;

   logic [VW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;
   logic          ram_we;
   logic [VW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   push_type      push;
   logic          push_ready;
   logic          pend_busy;

   pva_ram #(
      .WIDTH (EW),
      .DEPTH (VOICES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pva_ctrl #(
      .VOICES   (VOICES),
      .AGE_BITS (AGE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .push       (push),
      .push_ready (push_ready)
   );

   pva_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pend_busy  (pend_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `ASSERT_IMPLIES(a_accept_flushed, clock, reset, req_tvalid && req_tready, !pend_busy, "request taken while a result is still held back")
   `ASSERT_IMPLIES(a_push_has_action, clock, reset, push.valid && !push.fin, push.rsp.action != ACT_NONE, "empty result pushed mid-transaction")
   `ASSERT_IMPLIES(a_nonlast_successor, clock, reset, rsp_tvalid && !rsp_tlast, pend_busy, "non-final response without a following result")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request side ready straight after a transaction")

endmodule

>>> rtl/pva_ram.sv
module pva_ram #(
   parameter int WIDTH = 41,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/pva_ctrl.sv
module pva_ctrl #(
   parameter int VOICES   = 16,
   parameter int AGE_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [pva_pkg::REQ_W-1:0]                req_tdata,
   output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] ram_raddr,
   input  logic [AGE_BITS+8:0]                      ram_rdata,
   output logic                                     ram_we,
   output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] ram_waddr,
   output logic [AGE_BITS+8:0]                      ram_wdata,
   output pva_pkg::push_type                        push,
   input  logic                                     push_ready
);

   import pva_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IW = (VW > VOICE_BITS) ? VW : VOICE_BITS;
   localparam int EW = AGE_BITS + 9;
   localparam int CW = $clog2(MAX_RESULTS + 1);
   localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_START  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      MODE_PICK,
      MODE_REL,
      MODE_PREL,
      MODE_ANO,
      MODE_TICK
   } mode_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [6:0]           note_ff, note_in;
   logic [6:0]           vel_ff, vel_in;
   logic [DONE_BITS-1:0] done_ff, done_in;
   logic                 pedal_ff, pedal_in;
   logic [VW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [VOICES-1:0]    valid_ff, valid_in;
   logic                 match_found_ff, match_found_in;
   logic [VW-1:0]        match_idx_ff, match_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [VW-1:0]        free_idx_ff, free_idx_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic [VW-1:0]        best_idx_ff, best_idx_in;

   logic [2:0]           req_op;
   logic [6:0]           req_note;
   logic [6:0]           req_velocity;
   logic [6:0]           req_pedal_value;
   logic [DONE_BITS-1:0] req_done_mask;

   logic [EW-1:0]        entry;
   logic                 ent_act;
   logic [6:0]           ent_note;
   logic                 ent_sus;
   logic [AGE_BITS-1:0]  ent_age;
   logic                 hit;
   logic [IW-1:0]        idx_wide;
   logic                 done_bit;
   logic                 room;
   logic                 emit_cond;
   logic                 wr_cond;
   logic                 need;
   logic                 stall;
   logic [VW-1:0]        chosen;
   logic [IW-1:0]        chosen_wide;

   assign req_op          = req_tdata[2:0];
   assign req_note        = req_tdata[9:3];
   assign req_velocity    = req_tdata[16:10];
   assign req_pedal_value = req_tdata[23:17];
   assign req_done_mask   = req_tdata[39:24];

   assign req_tready = (state_ff == ST_IDLE);

   // never-written entries read as the reset record
   assign entry    = valid_ff[idx_ff] ? ram_rdata : '0;
   assign ent_age  = entry[AGE_BITS-1:0];
   assign ent_sus  = entry[AGE_BITS];
   assign ent_note = entry[AGE_BITS+7:AGE_BITS+1];
   assign ent_act  = entry[AGE_BITS+8];

   assign hit      = ent_act && (ent_note == note_ff);
   assign idx_wide = IW'(idx_ff);
   // only the first sixteen voices have a done bit
   assign done_bit = ((idx_wide >> VOICE_BITS) == '0) && done_ff[idx_wide[VOICE_BITS-1:0]];
   assign room     = (cnt_ff < CW'(MAX_RESULTS));

   assign chosen      = match_found_ff ? match_idx_ff :
                        free_found_ff  ? free_idx_ff  : best_idx_ff;
   assign chosen_wide = IW'(chosen);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      note_in        = note_ff;
      vel_in         = vel_ff;
      done_in        = done_ff;
      pedal_in       = pedal_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      valid_in       = valid_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_age_in    = best_age_ff;
      best_idx_in    = best_idx_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = entry;
      push           = '0;
      emit_cond      = 1'b0;
      wr_cond        = 1'b0;
      need           = 1'b0;
      stall          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               note_in        = req_note;
               vel_in         = req_velocity;
               done_in        = req_done_mask;
               idx_in         = '0;
               cnt_in         = '0;
               match_found_in = 1'b0;
               match_idx_in   = '0;
               free_found_in  = 1'b0;
               free_idx_in    = '0;
               best_age_in    = '0;
               best_idx_in    = '0;
               state_in       = ST_SCAN;
               unique case (req_op)
                  OP_NOTE_ON: begin
                     mode_in = (req_velocity != 7'd0) ? MODE_PICK : MODE_REL;
                  end
                  OP_NOTE_OFF: begin
                     mode_in = MODE_REL;
                  end
                  OP_SUSTAIN: begin
                     pedal_in = (req_pedal_value >= PEDAL_THRESHOLD);
                     mode_in  = MODE_PREL;
                     if (req_pedal_value >= PEDAL_THRESHOLD) begin
                        state_in = ST_FINISH;
                     end
                  end
                  OP_ALL_OFF: begin
                     mode_in = MODE_ANO;
                  end
                  OP_TICK: begin
                     mode_in = MODE_TICK;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            unique case (mode_ff)
               MODE_REL: begin
                  emit_cond = hit && !pedal_ff;
                  wr_cond   = hit && pedal_ff;
                  ram_wdata = {ent_act, ent_note, 1'b1, ent_age};
               end
               MODE_PREL: begin
                  emit_cond = ent_sus;
                  wr_cond   = ent_sus;
                  ram_wdata = {ent_act, ent_note, 1'b0, ent_age};
               end
               MODE_ANO: begin
                  emit_cond = ent_act;
               end
               MODE_TICK: begin
                  wr_cond = ent_act;
                  if (done_bit) begin
                     ram_wdata = {1'b0, 7'd0, ent_sus, ent_age + AGE_BITS'(1)};
                  end else begin
                     ram_wdata = {ent_act, ent_note, ent_sus, ent_age + AGE_BITS'(1)};
                  end
               end
               default: begin
               end
            endcase

            // key-ups past the result limit are dropped, state still updates
            need  = emit_cond && room;
            stall = need && !push_ready;

            push.valid       = need;
            push.fin         = 1'b0;
            push.rsp.action  = ACT_KEYUP;
            push.rsp.voice   = idx_wide[VOICE_BITS-1:0];
            push.rsp.note    = 7'd0;
            push.rsp.velocity = 7'd0;

            if (!stall) begin
               if (wr_cond) begin
                  ram_we           = 1'b1;
                  valid_in[idx_ff] = 1'b1;
               end
               if (need) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               if (mode_ff == MODE_PICK) begin
                  if (hit && !match_found_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = idx_ff;
                  end
                  if (!ent_act && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = idx_ff;
                  end
                  if (ent_age > best_age_ff) begin
                     best_age_in = ent_age;
                     best_idx_in = idx_ff;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = (mode_ff == MODE_PICK) ? ST_START : ST_FINISH;
               end else begin
                  idx_in = idx_ff + VW'(1);
               end
            end
         end

         ST_START: begin
            push.valid        = 1'b1;
            push.fin          = 1'b0;
            push.rsp.action   = ACT_START;
            push.rsp.voice    = chosen_wide[VOICE_BITS-1:0];
            push.rsp.note     = note_ff;
            push.rsp.velocity = vel_ff;
            ram_waddr         = chosen;
            ram_wdata         = {1'b1, note_ff, 1'b0, AGE_BITS'(0)};
            if (push_ready) begin
               ram_we           = 1'b1;
               valid_in[chosen] = 1'b1;
               state_in         = ST_FINISH;
            end
         end

         ST_FINISH: begin
            push.valid = 1'b1;
            push.fin   = 1'b1;
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read ahead: the entry needed next cycle
      ram_raddr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         pedal_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pedal_ff <= pedal_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      note_ff        <= note_in;
      vel_ff         <= vel_in;
      done_ff        <= done_in;
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      best_age_ff    <= best_age_in;
      best_idx_ff    <= best_idx_in;
   end

endmodule

>>> rtl/pva_out.sv
module pva_out (
   input  logic                      clock,
   input  logic                      reset,
   input  pva_pkg::push_type         push,
   output logic                      push_ready,
   output logic                      pend_busy,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [pva_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   import pva_pkg::*;

   // one result is held back until the next one (or the end) shows whether it is last
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    mv_ok;
   rsp_type nothing;

   assign mv_ok = !out_valid_ff || rsp_tready;
   assign push_ready = pend_valid_ff ? mv_ok : (!push.fin || mv_ok);

   always_comb begin
      nothing        = '0;
      nothing.action = ACT_NONE;
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (push.valid && push_ready) begin
         if (!push.fin) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
               out_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_in       = push.rsp;
         end else begin
            out_valid_in  = 1'b1;
            out_in        = pend_valid_ff ? pend_ff : nothing;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign pend_busy  = pend_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_BITS){1'b0}}, out_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
